@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, off during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication with the consequent checked in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/uvsph_pkg.sv @@
`default_nettype none
package uvsph_pkg;

  localparam int unsigned CordicStagesDefault = 16;
  localparam int unsigned AtanEntries = 24;
  localparam logic [7:0] PrecisionReset = 8'd48;
  localparam logic signed [33:0] CordicX0 = 34'sd652032874;
  // Divider quotient width: dividend up to 255*131072+255 over 2*p.
  localparam int unsigned QuotW = 25;

  typedef struct packed {
    logic [7:0] row;
    logic [7:0] column;
  } in_t;

  typedef struct packed {
    logic              valid_res;
    logic [15:0]       vertex_index;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] position_x;
    logic signed [15:0] position_y;
    logic signed [15:0] position_z;
    logic [15:0]       tex_u;
    logic [15:0]       tex_v;
  } out_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [29:0] atan_turns(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0: r = 30'd536870912;  5'd1: r = 30'd316933406;
      5'd2: r = 30'd167458907;  5'd3: r = 30'd85004756;
      5'd4: r = 30'd42667331;   5'd5: r = 30'd21354465;
      5'd6: r = 30'd10680350;   5'd7: r = 30'd5340245;
      5'd8: r = 30'd2670163;    5'd9: r = 30'd1335087;
      5'd10: r = 30'd667544;    5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;    5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;     5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;     5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;       5'd21: r = 30'd326;
      5'd22: r = 30'd163;       5'd23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    logic signed [15:0] r;
    if (v > 36'sd32767) r = 16'sh7fff;
    else if (v < -36'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // Q1.30 to Q1.15: add half, floor shift, saturate.
  function automatic logic signed [15:0] round_q30(input logic signed [33:0] v);
    logic signed [35:0] t;
    t = (36'(v) + 36'sd16384) >>> 15;
    return sat16(t);
  endfunction

endpackage
`default_nettype wire

@@ rtl/uvsph_div.sv @@
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage, three quotients
// per beat sharing one divisor. A side payload rides along.
module uvsph_div #(
  parameter int unsigned SideW = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [uvsph_pkg::QuotW-1:0] num_a,
  input  wire logic [uvsph_pkg::QuotW-1:0] num_b,
  input  wire logic [uvsph_pkg::QuotW-1:0] num_c,
  input  wire logic [8:0]                den,
  input  wire logic [SideW-1:0]          side_in,
  output logic                           out_valid,
  output logic [uvsph_pkg::QuotW-1:0]    quo_a,
  output logic [uvsph_pkg::QuotW-1:0]    quo_b,
  output logic [uvsph_pkg::QuotW-1:0]    quo_c,
  output logic [SideW-1:0]               side_out
);
  localparam int unsigned W = uvsph_pkg::QuotW;

  logic [W:1]       vld;
  logic [W-1:0]     na [1:W];
  logic [W-1:0]     nb [1:W];
  logic [W-1:0]     nc [1:W];
  logic [9:0]       ra [1:W];
  logic [9:0]       rb [1:W];
  logic [9:0]       rc [1:W];
  logic [8:0]       dv [1:W];
  logic [SideW-1:0] sd [1:W];

  for (genvar s = 0; s < W; s++) begin : g_stage
    logic             vi;
    logic [W-1:0]     ai, bi, ci;
    logic [9:0]       rai, rbi, rci;
    logic [8:0]       di;
    logic [SideW-1:0] si;
    logic [9:0]       ta, tb, tc;
    if (s == 0) begin : g_first
      always_comb begin
        vi = in_valid;
        ai = num_a; bi = num_b; ci = num_c;
        rai = '0; rbi = '0; rci = '0;
        di = den; si = side_in;
      end
    end else begin : g_next
      always_comb begin
        vi = vld[s];
        ai = na[s]; bi = nb[s]; ci = nc[s];
        rai = ra[s]; rbi = rb[s]; rci = rc[s];
        di = dv[s]; si = sd[s];
      end
    end
    always_comb begin
      ta = {rai[8:0], ai[W-1]};
      tb = {rbi[8:0], bi[W-1]};
      tc = {rci[8:0], ci[W-1]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vi;
      end
      if (en) begin
        dv[s+1] <= di;
        sd[s+1] <= si;
        if (ta >= {1'b0, di}) begin
          ra[s+1] <= ta - {1'b0, di};
          na[s+1] <= {ai[W-2:0], 1'b1};
        end else begin
          ra[s+1] <= ta;
          na[s+1] <= {ai[W-2:0], 1'b0};
        end
        if (tb >= {1'b0, di}) begin
          rb[s+1] <= tb - {1'b0, di};
          nb[s+1] <= {bi[W-2:0], 1'b1};
        end else begin
          rb[s+1] <= tb;
          nb[s+1] <= {bi[W-2:0], 1'b0};
        end
        if (tc >= {1'b0, di}) begin
          rc[s+1] <= tc - {1'b0, di};
          nc[s+1] <= {ci[W-2:0], 1'b1};
        end else begin
          rc[s+1] <= tc;
          nc[s+1] <= {ci[W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vld[W];
  assign quo_a = na[W];
  assign quo_b = nb[W];
  assign quo_c = nc[W];
  assign side_out = sd[W];
endmodule
`default_nettype wire

@@ rtl/uvsph_cordic.sv @@
`default_nettype none
// Rotation-mode CORDIC pipeline, one micro-rotation per stage, two angles
// per beat. Gives sin and cos in Q1.15 from the output register after the last rotation.
module uvsph_cordic #(
  parameter int unsigned Stages = uvsph_pkg::CordicStagesDefault,
  parameter int unsigned SideW = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [15:0]       phase_a,
  input  wire logic [15:0]       phase_b,
  input  wire logic [SideW-1:0]  side_in,
  output logic                   out_valid,
  output logic signed [15:0]     sin_a,
  output logic signed [15:0]     cos_a,
  output logic signed [15:0]     sin_b,
  output logic signed [15:0]     cos_b,
  output logic [SideW-1:0]       side_out
);
  localparam int unsigned N = (Stages < uvsph_pkg::AtanEntries) ? Stages
                                                                 : uvsph_pkg::AtanEntries;

  logic                      vld [N+2];
  logic signed [33:0]        xa [N+1], ya [N+1], xb [N+1], yb [N+1];
  logic signed [33:0]        za [N+1], zb [N+1];
  logic                      nga [N+1], ngb [N+1];
  logic [SideW-1:0]          sd [N+2];

  function automatic logic signed [33:0] fold_z(input logic [15:0] ph);
    logic signed [33:0] z;
    z = $signed({2'b00, ph, 16'h0000});
    case (ph[15:14])
      2'd1, 2'd2: z = z - 34'sh080000000;
      2'd3:       z = z - 34'sh100000000;
      default:    z = z;
    endcase
    return z;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      sd[0] <= side_in;
      xa[0] <= uvsph_pkg::CordicX0; ya[0] <= '0;
      xb[0] <= uvsph_pkg::CordicX0; yb[0] <= '0;
      za[0] <= fold_z(phase_a);
      zb[0] <= fold_z(phase_b);
      nga[0] <= (phase_a[15:14] == 2'd1) || (phase_a[15:14] == 2'd2);
      ngb[0] <= (phase_b[15:14] == 2'd1) || (phase_b[15:14] == 2'd2);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic [4:0] Idx = 5'(i);
    logic signed [33:0] at;
    assign at = $signed({4'b0000, uvsph_pkg::atan_turns(Idx)});
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        sd[i+1] <= sd[i];
        nga[i+1] <= nga[i];
        ngb[i+1] <= ngb[i];
        if (!za[i][33]) begin
          xa[i+1] <= xa[i] - (ya[i] >>> i);
          ya[i+1] <= ya[i] + (xa[i] >>> i);
          za[i+1] <= za[i] - at;
        end else begin
          xa[i+1] <= xa[i] + (ya[i] >>> i);
          ya[i+1] <= ya[i] - (xa[i] >>> i);
          za[i+1] <= za[i] + at;
        end
        if (!zb[i][33]) begin
          xb[i+1] <= xb[i] - (yb[i] >>> i);
          yb[i+1] <= yb[i] + (xb[i] >>> i);
          zb[i+1] <= zb[i] - at;
        end else begin
          xb[i+1] <= xb[i] + (yb[i] >>> i);
          yb[i+1] <= yb[i] - (xb[i] >>> i);
          zb[i+1] <= zb[i] + at;
        end
      end
    end
  end

  // Negate for the folded half turn, then round to Q1.15.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[N+1] <= 1'b0;
    end else if (en) begin
      vld[N+1] <= vld[N];
    end
    if (en) begin
      sd[N+1] <= sd[N];
      cos_a <= uvsph_pkg::round_q30(nga[N] ? -xa[N] : xa[N]);
      sin_a <= uvsph_pkg::round_q30(nga[N] ? -ya[N] : ya[N]);
      cos_b <= uvsph_pkg::round_q30(ngb[N] ? -xb[N] : xb[N]);
      sin_b <= uvsph_pkg::round_q30(ngb[N] ? -yb[N] : yb[N]);
    end
  end

  assign out_valid = vld[N+1];
  assign side_out = sd[N+1];
endmodule
`default_nettype wire

@@ rtl/uv_sphere_vertex_generator.sv @@
`default_nettype none
// UV sphere vertex generator.
// Input channel (in_valid/in_ready, in_data) takes one grid point (row,
// column) per beat; output channel (out_valid/out_ready, out_data) returns
// one vertex per beat: index, unit normal, halved position and texture
// coordinates. Points outside the grid come back with every field zero.
// Configuration channel (cfg_valid/cfg_ready, cfg_data) writes precision;
// write it only while no point is in flight. Reset sets precision to 48.
// Throughput: one point per cycle while the receiver does not stall. The
// pipeline holds 25 divider stages, the CORDIC input, rotation and output
// registers, a product register and the output register; its length is
// set by the bit-per-stage divider and the one-rotation-per-stage CORDIC.
// When the receiver stalls, the whole pipeline holds in place; in_ready
// stays high while the output register is empty or being taken.
// Reset clears all valid bits; results in flight are dropped.
`include "assert_macros.svh"
module uv_sphere_vertex_generator #(
  parameter int unsigned CORDIC_STAGES = uvsph_pkg::CordicStagesDefault
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire uvsph_pkg::in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output uvsph_pkg::out_t      out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [7:0]      cfg_data
);
  localparam int unsigned QW = uvsph_pkg::QuotW;
  // Side payload: ok, row, column, precision
  localparam int unsigned SW = 25;

  logic [7:0] precision;
  logic       en;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      precision <= uvsph_pkg::PrecisionReset;
    end else if (cfg_valid && cfg_ready) begin
      precision <= cfg_data;
    end
  end

  // Stage 0: operands for theta, phi and tex_v; tex_u equals phi.
  logic          ok0;
  logic [8:0]    den0;
  logic [QW-1:0] na, nb, nc;
  always_comb begin
    ok0 = (precision != 8'd0) && (in_data.row <= precision)
          && (in_data.column <= precision);
    den0 = {precision, 1'b0};
    na = QW'({in_data.row, 17'd0}) + QW'(precision);
    nb = QW'({in_data.column, 16'd0}) + QW'(precision);
    nc = QW'({in_data.row, 16'd0}) + QW'(precision);
  end

  logic          dv_valid;
  logic [QW-1:0] qa, qb, qc;
  logic [SW-1:0] dside;
  uvsph_div #(.SideW(SW)) u_div (
    .clk, .rst, .en,
    .in_valid(in_valid && in_ready),
    .num_a(na), .num_b(nb), .num_c(nc),
    .den(ok0 ? den0 : 9'd1),
    .side_in({ok0, in_data.row, in_data.column, precision}),
    .out_valid(dv_valid),
    .quo_a(qa), .quo_b(qb), .quo_c(qc),
    .side_out(dside)
  );

  // Side through the CORDIC: ok, vertex index, tex_u, tex_v
  localparam int unsigned CW = 49;
  logic                 cv;
  logic signed [15:0]   st, ct, sp, cp;
  logic [CW-1:0]        cside;
  logic [15:0]          vidx;
  always_comb begin
    vidx = 16'(dside[23:16]) * 16'({1'b0, dside[7:0]} + 9'd1) + 16'(dside[15:8]);
  end
  uvsph_cordic #(.Stages(CORDIC_STAGES), .SideW(CW)) u_cordic (
    .clk, .rst, .en,
    .in_valid(dv_valid),
    .phase_a(qa[15:0]), .phase_b(qb[15:0]),
    .side_in({dside[24], vidx, qb[15:0], qc[15:0]}),
    .out_valid(cv),
    .sin_a(st), .cos_a(ct), .sin_b(sp), .cos_b(cp),
    .side_out(cside)
  );

  // Products stage
  logic               pv;
  logic signed [15:0] nx, ny, nz;
  logic [CW-1:0]      pside;
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= cv;
    end
    if (en) begin
      nx <= uvsph_pkg::sat16((36'(sp * ct) + 36'sd16384) >>> 15);
      nz <= uvsph_pkg::sat16((36'(sp * st) + 36'sd16384) >>> 15);
      ny <= cp;
      pside <= cside;
    end
  end

  function automatic logic signed [15:0] halve(input logic signed [15:0] n);
    logic signed [16:0] t;
    t = (17'(n) + 17'sd1) >>> 1;
    return t[15:0];
  endfunction

  // Output register; the pipeline advances whenever it is free or drained.
  assign en = !out_valid || out_ready;
  assign in_ready = en;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= pv;
    end
    if (en) begin
      if (pside[48]) begin
        out_data.valid_res <= 1'b1;
        out_data.vertex_index <= pside[47:32];
        out_data.normal_x <= nx;
        out_data.normal_y <= ny;
        out_data.normal_z <= nz;
        out_data.position_x <= halve(nx);
        out_data.position_y <= halve(ny);
        out_data.position_z <= halve(nz);
        out_data.tex_u <= pside[31:16];
        out_data.tex_v <= pside[15:0];
      end else begin
        out_data <= '0;
      end
    end
  end

  `ASSERT_IMPL(a_stall_holds, clk, rst, out_valid && !out_ready, !in_ready,
               "input accepted while output stalled")
  `ASSERT_NEXT(a_out_held, clk, rst, out_valid && !out_ready, out_valid,
               "output dropped under stall")
  `ASSERT_IMPL(a_invalid_zero, clk, rst, out_valid && !out_data.valid_res,
               out_data.vertex_index == 16'd0 && out_data.tex_u == 16'd0,
               "off-grid result not cleared")
endmodule
`default_nettype wire

@@ test/uv_sphere_vertex_generator_checker.sv @@
`timescale 1ns / 100ps
module uv_sphere_vertex_generator_checker #(
  parameter int unsigned CORDIC_STAGES = uvsph_pkg::CordicStagesDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  uvsph_pkg::in_t  in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  uvsph_pkg::out_t out_data,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [7:0]      cfg_data,
  output int              failures,
  output int              pending
);

  localparam longint unsigned ArctanTurns [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10680350, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41722,
    20861, 10430, 5215, 2608, 1304,
    652, 326, 163, 81
  };

  logic [7:0]      grid_prec;
  uvsph_pkg::out_t vertex_q[$];
  int              fail_cnt;

  function automatic longint clamp16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Rotation-mode CORDIC on a 16-bit phase, folded to the right half plane.
  function automatic void phase_sincos(input int unsigned phase, output longint s,
                                       output longint c);
    longint x, y, z, dx, dy;
    int unsigned quad;
    bit flip;
    x = uvsph_pkg::CordicX0;
    y = 0;
    z = longint'(phase & 32'hFFFF) * 65536;
    quad = (phase >> 14) & 3;
    flip = 0;
    if (quad == 1 || quad == 2) begin
      z = z - 64'sd2147483648;
      flip = 1;
    end else if (quad == 3) begin
      z = z - 64'sd4294967296;
    end
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ArctanTurns[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ArctanTurns[i]);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clamp16((x + 16384) >>> 15);
    s = clamp16((y + 16384) >>> 15);
  endfunction

  function automatic uvsph_pkg::out_t vertex_of(input uvsph_pkg::in_t pt,
                                                input logic [7:0] prec);
    uvsph_pkg::out_t v;
    int unsigned p, r, col, theta, phi;
    longint st, ct, sp, cp, nx, ny, nz;
    v = '0;
    p = prec;
    r = pt.row;
    col = pt.column;
    if (p == 0 || r > p || col > p) return v;
    theta = ((r * 131072 + p) / (2 * p)) & 32'hFFFF;
    phi = (col * 65536 + p) / (2 * p);
    phase_sincos(theta, st, ct);
    phase_sincos(phi, sp, cp);
    nx = clamp16((sp * ct + 16384) >>> 15);
    ny = cp;
    nz = clamp16((sp * st + 16384) >>> 15);
    v.valid_res = 1'b1;
    v.vertex_index = 16'(r * (p + 1) + col);
    v.normal_x = 16'(nx);
    v.normal_y = 16'(ny);
    v.normal_z = 16'(nz);
    v.position_x = 16'((nx + 1) >>> 1);
    v.position_y = 16'((ny + 1) >>> 1);
    v.position_z = 16'((nz + 1) >>> 1);
    v.tex_u = 16'(phi);
    v.tex_v = 16'((r * 65536 + p) / (2 * p));
    return v;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_cnt++;
  endtask

  task automatic compare_vertex(input uvsph_pkg::out_t got, input uvsph_pkg::out_t want);
    if (got.valid_res !== want.valid_res) report("valid_res", got.valid_res, want.valid_res);
    if (got.vertex_index !== want.vertex_index)
      report("vertex_index", got.vertex_index, want.vertex_index);
    if (got.normal_x !== want.normal_x) report("normal_x", got.normal_x, want.normal_x);
    if (got.normal_y !== want.normal_y) report("normal_y", got.normal_y, want.normal_y);
    if (got.normal_z !== want.normal_z) report("normal_z", got.normal_z, want.normal_z);
    if (got.position_x !== want.position_x)
      report("position_x", got.position_x, want.position_x);
    if (got.position_y !== want.position_y)
      report("position_y", got.position_y, want.position_y);
    if (got.position_z !== want.position_z)
      report("position_z", got.position_z, want.position_z);
    if (got.tex_u !== want.tex_u) report("tex_u", got.tex_u, want.tex_u);
    if (got.tex_v !== want.tex_v) report("tex_v", got.tex_v, want.tex_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      grid_prec = uvsph_pkg::PrecisionReset;
      vertex_q.delete();
    end else begin
      // A point taken on the same edge as a write still sees the old precision.
      if (in_valid && in_ready) vertex_q = {vertex_q, vertex_of(in_data, grid_prec)};
      if (cfg_valid && cfg_ready) grid_prec = cfg_data;
      if (out_valid && out_ready) begin
        if (vertex_q.size() == 0) begin
          report("unexpected output beat, index", out_data.vertex_index, 0);
        end else begin
          compare_vertex(out_data, vertex_q.pop_front());
        end
      end
    end
    failures <= fail_cnt;
    pending <= vertex_q.size();
  end

endmodule

@@ test/uv_sphere_vertex_generator_tb.sv @@
`timescale 1ns / 100ps
module uv_sphere_vertex_generator_tb;

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  uvsph_pkg::in_t  in_data;
  logic            out_valid;
  logic            out_ready;
  uvsph_pkg::out_t out_data;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [7:0]      cfg_data;
  int              failures;
  int              pending;
  int              points_sent;
  int              burst_left;

  uv_sphere_vertex_generator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  uv_sphere_vertex_generator_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .failures  (failures),
    .pending   (pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Receiver: draw its stall style at random from four styles.
  int stall_mode;
  int stall_cnt;
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= ((stall_cnt / 8) % 2 == 0);
    endcase
  end

  task automatic send_point(input logic [7:0] r, input logic [7:0] c);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_data.row <= r;
    in_data.column <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    points_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_precision(input logic [7:0] p);
    cfg_valid <= 1'b1;
    cfg_data <= p;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_coord(input int p);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0 || p >= 254) return 8'($urandom_range(0, 255));
    if (roll == 1) return 8'(p + 1);
    return 8'($urandom_range(0, p));
  endfunction

  int precs[8] = '{48, 1, 255, 0, 7, 2, 100, 200};

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    points_sent = 0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    precs[7] = $urandom_range(3, 254);
    for (int ph = 0; ph < 8; ph++) begin
      int p;
      p = precs[ph];
      // Reset value covers the first phase; write all the others.
      if (ph != 0) set_precision(8'(p));
      // Corners, the grid edge, just past it, and the far extremes.
      if (ph < 4) begin
        send_point(8'd0, 8'd0);
        send_point(8'(p), 8'(p));
        send_point(8'(p), 8'd0);
        send_point(8'(p + 1), 8'd0);
        send_point(8'd0, 8'(p + 1));
        send_point(8'hff, 8'hff);
      end
      for (int k = 0; k < 105; k++) send_point(pick_coord(p), pick_coord(p));
      drain();
    end
    repeat (60) @(posedge clk);
    $display("covered %0d grid points over 8 precision settings (0, 1, 255 among them)",
             points_sent);
    $display("inside and outside the grid, with random sender gaps and receiver stalls");
    if (failures == 0) begin
      $display("uv_sphere_vertex_generator regression: pass");
    end else begin
      $display("uv_sphere_vertex_generator regression: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("uv_sphere_vertex_generator regression: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/uvsph_pkg.sv
rtl/uvsph_div.sv
rtl/uvsph_cordic.sv
rtl/uv_sphere_vertex_generator.sv
test/uv_sphere_vertex_generator_checker.sv
test/uv_sphere_vertex_generator_tb.sv
